// ===== hw/rtl/fcd_pkg.sv =====
`default_nettype none
package fcd_pkg;
	localparam int FramePixels = 307200;
	localparam int PosW = $clog2(FramePixels);
	localparam int CountW = 19;
	localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
	localparam int ValW = 64;
	localparam int MemW = ValW + 1;
	localparam int DivSteps = 16;

	localparam logic [1:0] RegDepth = 2'd0;
	localparam logic [1:0] RegChroma = 2'd1;
	localparam logic [1:0] RegRatio = 2'd2;

	typedef struct packed {
		logic        in_region;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] depth_mm;
		logic        frame_end;
	} in_item_t;

	typedef struct packed {
		logic              frame_changed;
		logic [CountW-1:0] changed_count;
		logic [CountW-1:0] considered_count;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic compare;
		logic mem_write;
		logic mul_lo;
		logic mul_hi;
		logic finish;
		logic clear_step;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic clear_done;
	} status_t;
endpackage
`default_nettype wire

// ===== hw/rtl/fcd_ram.sv =====
`default_nettype none
module fcd_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/fcd_datapath.sv =====
`default_nettype none
module fcd_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire fcd_pkg::cmd_t        cmd,
	output fcd_pkg::status_t          status,
	input  wire fcd_pkg::in_item_t    item,
	input  wire logic [15:0]          depth_limit,
	input  wire logic [16:0]          chroma_limit,
	input  wire logic [16:0]          ratio_limit,
	output fcd_pkg::out_item_t        result
);
	fcd_pkg::in_item_t item_q;
	logic [fcd_pkg::PosW-1:0] pos_q, clr_q, waddr;
	logic [fcd_pkg::CountW-1:0] changed_q, considered_q;
	logic [9:0] sum_q;
	// restoring dividers, one quotient bit per step, for the three channels
	logic [15:0] quo_q [3];
	logic [23:0] rem_q [3];
	logic [4:0] step_q;
	logic [4:0] bitn;
	logic [24:0] sum_sh;
	logic [fcd_pkg::MemW-1:0] rdata, wdata;
	logic we;
	logic was_in;
	logic [15:0] ocr, ocg, ocb, od;
	logic [15:0] dd, dr, dg, db;
	logic [17:0] cdiff;
	logic changed;
	logic [26:0] lo_prod;
	logic [25:0] hi_prod;
	logic [26:0] prod_q;
	logic [36:0] rhs_q;

	// divisor aligned to the current quotient bit
	assign bitn = 5'd15 - step_q;
	assign sum_sh = 25'(sum_q) << bitn;

	// latch request, then bit-serial quotient: remainder against shifted divisor
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
			sum_q <= 10'(item.red) + 10'(item.green) + 10'(item.blue);
			rem_q[0] <= 24'({item.red, 15'd0});
			rem_q[1] <= 24'({item.green, 15'd0});
			rem_q[2] <= 24'({item.blue, 15'd0});
			for (int i = 0; i < 3; i++) quo_q[i] <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			for (int i = 0; i < 3; i++) begin
				if (sum_q != 10'd0 && 25'(rem_q[i]) >= sum_sh) begin
					quo_q[i][bitn[3:0]] <= 1'b1;
					rem_q[i] <= rem_q[i] - sum_sh[23:0];
				end
			end
			step_q <= step_q + 5'd1;
		end
	end

	// previous frame store
	assign waddr = cmd.clear_step ? clr_q : pos_q;
	assign we = cmd.clear_step | cmd.mem_write;
	assign wdata = cmd.clear_step ? {1'b1, 64'd0} :
		(item_q.in_region ? {1'b1, item_q.depth_mm, quo_q[2], quo_q[1], quo_q[0]}
			: '0);
	fcd_ram #(.Width(fcd_pkg::MemW), .Depth(fcd_pkg::FramePixels)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(pos_q), .rdata(rdata)
	);

	assign was_in = rdata[64];
	assign ocr = rdata[15:0];
	assign ocg = rdata[31:16];
	assign ocb = rdata[47:32];
	assign od = rdata[63:48];
	assign dd = item_q.depth_mm > od ? item_q.depth_mm - od : od - item_q.depth_mm;
	assign dr = quo_q[0] > ocr ? quo_q[0] - ocr : ocr - quo_q[0];
	assign dg = quo_q[1] > ocg ? quo_q[1] - ocg : ocg - quo_q[1];
	assign db = quo_q[2] > ocb ? quo_q[2] - ocb : ocb - quo_q[2];
	assign cdiff = 18'(dr) + 18'(dg) + 18'(db);
	assign changed = !was_in || dd > depth_limit || cdiff > 18'(chroma_limit);

	// counters and position; the counters clear when the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			clr_q <= '0;
			changed_q <= '0;
			considered_q <= '0;
		end else begin
			if (cmd.clear_step) clr_q <= clr_q + 1'b1;
			if (cmd.compare) begin
				if (item_q.in_region || was_in) begin
					if (considered_q != fcd_pkg::CountMax) considered_q <= considered_q + 1'b1;
					if ((!item_q.in_region || changed) && changed_q != fcd_pkg::CountMax)
						changed_q <= changed_q + 1'b1;
				end
			end
			if (cmd.mem_write) begin
				if (item_q.frame_end || pos_q == fcd_pkg::PosW'(fcd_pkg::FramePixels - 1))
					pos_q <= '0;
				else
					pos_q <= pos_q + 1'b1;
			end
			if (cmd.finish) begin
				changed_q <= '0;
				considered_q <= '0;
			end
		end
	end

	// limit * considered split into 17x10 and 17x9 partial products
	assign lo_prod = ratio_limit * considered_q[9:0];
	assign hi_prod = ratio_limit * considered_q[18:10];
	always_ff @(posedge clk) begin
		if (cmd.mul_lo) prod_q <= lo_prod;
		if (cmd.mul_hi) rhs_q <= {10'd0, prod_q} + {1'b0, hi_prod, 10'd0};
	end

	assign result.frame_changed = {2'd0, changed_q, 16'd0} > rhs_q;
	assign result.changed_count = changed_q;
	assign result.considered_count = considered_q;
	assign status.last = item_q.frame_end;
	assign status.clear_done = clr_q == fcd_pkg::PosW'(fcd_pkg::FramePixels - 1);
endmodule
`default_nettype wire

// ===== hw/rtl/fcd_ctrl.sv =====
`default_nettype none
module fcd_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire fcd_pkg::status_t status,
	output fcd_pkg::cmd_t         cmd
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DIV, S_READ, S_CMP, S_WRITE, S_MUL0, S_MUL1, S_OUT
	} state_t;
	state_t state_q;
	logic [4:0] cnt_q;

	always_comb begin
		cmd = '0;
		cmd.clear_step = state_q == S_CLEAR;
		cmd.load = state_q == S_IDLE && in_valid;
		cmd.div_step = state_q == S_DIV;
		cmd.compare = state_q == S_CMP;
		cmd.mem_write = state_q == S_WRITE;
		cmd.mul_lo = state_q == S_MUL0;
		cmd.mul_hi = state_q == S_MUL1;
		cmd.finish = state_q == S_OUT && out_ready;
	end
	assign in_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_OUT;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: if (status.clear_done) state_q <= S_IDLE;
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DIV;
						cnt_q <= '0;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(fcd_pkg::DivSteps - 1)) state_q <= S_READ;
				end
				S_READ: state_q <= S_CMP;
				S_CMP: state_q <= S_WRITE;
				S_WRITE: state_q <= status.last ? S_MUL0 : S_IDLE;
				S_MUL0: state_q <= S_MUL1;
				S_MUL1: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/frame_change_detector_top.sv =====
`default_nettype none
// Frame change detector. Pixels enter one request at a time; each is accepted,
// run through the bit-serial chromaticity divider, then store read, compare
// and store write, and a frame-end pixel adds the low and high multiply steps
// before the result request, which then holds until it is taken. After reset
// a clearing pass sets the frame store to all ones mask and zero values; no
// pixel is accepted during it.
module frame_change_detector_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire fcd_pkg::in_item_t    in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output fcd_pkg::out_item_t        out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [16:0]          cfg_data
);
	fcd_pkg::cmd_t cmd;
	fcd_pkg::status_t status;
	logic [15:0] depth_q;
	logic [16:0] chroma_q, ratio_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= 16'd10;
			chroma_q <= 17'd3277;
			ratio_q <= 17'd6554;
		end else if (cfg_valid) begin
			if (cfg_index == fcd_pkg::RegDepth) depth_q <= cfg_data[15:0];
			if (cfg_index == fcd_pkg::RegChroma) chroma_q <= cfg_data;
			if (cfg_index == fcd_pkg::RegRatio) ratio_q <= cfg_data;
		end
	end

	fcd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .status(status), .cmd(cmd)
	);

	fcd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status), .item(in_data),
		.depth_limit(depth_q), .chroma_limit(chroma_q), .ratio_limit(ratio_q),
		.result(out_data)
	);
endmodule
`default_nettype wire
